### rtl/core/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg
// shared types and constants of the sorted priority queue
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DEFAULT_CAPACITY = 16;
    localparam int ID_W             = 16;
    localparam int PRI_W            = 8;
    localparam int OCC_W            = 5;

    typedef enum logic
    {
        REQ_INSERT = 1'b0,
        REQ_REMOVE = 1'b1
    } req_t;

    typedef enum logic [1:0]
    {
        ST_INSERTED = 2'd0,
        ST_REMOVED  = 2'd1,
        ST_EMPTY    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    typedef struct packed
    {
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } entry_t;

endpackage

### rtl/core/spq_if.sv
// ----------------------------------------------------------------------------
// spq_req_if / spq_res_if
// valid/ready channels for requests and results of the priority queue
// ----------------------------------------------------------------------------
interface spq_req_if;
    import spq_pkg::*;

    logic             valid;
    logic             ready;
    logic             req_type;
    logic [ID_W-1:0]  item_id;
    logic [PRI_W-1:0] priority_req;

    modport source (output valid, output req_type, output item_id, output priority_req,
                    input ready);
    modport sink   (input valid, input req_type, input item_id, input priority_req,
                    output ready);
endinterface

interface spq_res_if;
    import spq_pkg::*;

    logic             valid;
    logic             ready;
    logic [1:0]       status;
    logic [ID_W-1:0]  out_id;
    logic [PRI_W-1:0] out_priority;
    logic [OCC_W-1:0] occupancy;

    modport source (output valid, output status, output out_id, output out_priority,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input out_id, input out_priority,
                    input occupancy, output ready);
endinterface

### rtl/core/spq_store.sv
// ----------------------------------------------------------------------------
// spq_store
// entry memory: one write port and one registered read port
// ----------------------------------------------------------------------------
module spq_store #(
    parameter int DEPTH  = spq_pkg::DEFAULT_CAPACITY,
    parameter int ADDR_W = $clog2(spq_pkg::DEFAULT_CAPACITY)
) (
    input  logic                clk,
    input  logic                we,
    input  logic [ADDR_W-1:0]   waddr,
    input  spq_pkg::entry_t     wdata,
    input  logic [ADDR_W-1:0]   raddr,
    output spq_pkg::entry_t     rdata
);
    import spq_pkg::*;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue
// bounded priority queue kept sorted by descending priority, stable on ties
// ----------------------------------------------------------------------------
// Requests arrive on req (insert or remove), one result per request leaves on
// res with a status, the removed entry and the occupancy after the request.
// Entries sit in a circular buffer in one memory; a remove advances the head.
// An insert walks from the tail toward the head, one entry a cycle, moving
// each lower-priority entry up one slot through the single read and write
// port, then writes the new entry into the gap.
// Results: a refused insert, an insert into an empty queue and a remove from
// an empty queue give the result on the next cycle; a remove reads the head
// entry in S_POP; an insert passes S_SHIFT once per moved entry, then S_PLACE
// or a final S_SHIFT. One request is in flight at a time; req.ready is
// high only when the sequencer is idle and the result register is free or
// being drained.
// While res is stalled the result is held and no new request is taken.
// Reset empties the queue at once; memory contents are not cleared.
// ----------------------------------------------------------------------------
module stable_priority_queue #(
    parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
    input  logic       clk,
    input  logic       rst_n,
    spq_req_if.sink    req,
    spq_res_if.source  res
);
    import spq_pkg::*;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = CNT_W + 1;

    typedef enum logic [3:0]
    {
        S_IDLE  = 4'b0001,
        S_SHIFT = 4'b0010,
        S_PLACE = 4'b0100,
        S_POP   = 4'b1000
    } state_t;

    state_t           state_reg,   state_next;
    logic [IDX_W-1:0] head_reg,    head_next;
    logic [CNT_W-1:0] count_reg,   count_next;
    logic [CNT_W-1:0] pos_reg,     pos_next;
    entry_t           new_reg,     new_next;

    logic             res_valid_reg, res_valid_next;
    status_t          status_reg,    status_next;
    logic [ID_W-1:0]  out_id_reg,    out_id_next;
    logic [PRI_W-1:0] out_pri_reg,   out_pri_next;
    logic [OCC_W-1:0] occ_reg,       occ_next;

    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;
    entry_t           mem_rdata;
    logic             accept;
    entry_t           in_entry;

    // logical slot to physical address, wrapping once around the buffer
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [CNT_W-1:0] slot);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(slot);
        if (sum >= SUM_W'(CAPACITY))
        begin
            sum = sum - SUM_W'(CAPACITY);
        end
        return IDX_W'(sum);
    endfunction

    spq_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign req.ready = (state_reg == S_IDLE) && (!res_valid_reg || res.ready);
    assign accept    = req.valid && req.ready;
    assign in_entry  = '{id: req.item_id, pri: req.priority_req};

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        new_next       = new_reg;
        res_valid_next = res_valid_reg && !res.ready;
        status_next    = status_reg;
        out_id_next    = out_id_reg;
        out_pri_next   = out_pri_reg;
        occ_next       = occ_reg;
        mem_we         = 1'b0;
        mem_waddr      = phys(head_reg, pos_reg);
        mem_wdata      = new_reg;
        mem_raddr      = phys(head_reg, '0);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    new_next = in_entry;
                    if (req.req_type == REQ_INSERT)
                    begin
                        if (count_reg >= CNT_W'(CAPACITY))
                        begin
                            res_valid_next = 1'b1;
                            status_next    = ST_FULL;
                            out_id_next    = '0;
                            out_pri_next   = '0;
                            occ_next       = OCC_W'(count_reg);
                        end
                        else if (count_reg == '0)
                        begin
                            mem_we         = 1'b1;
                            mem_waddr      = phys(head_reg, '0);
                            mem_wdata      = in_entry;
                            count_next     = count_reg + 1'b1;
                            res_valid_next = 1'b1;
                            status_next    = ST_INSERTED;
                            out_id_next    = '0;
                            out_pri_next   = '0;
                            occ_next       = OCC_W'(count_reg + 1'b1);
                        end
                        else
                        begin
                            pos_next   = count_reg;
                            mem_raddr  = phys(head_reg, count_reg - 1'b1);
                            state_next = S_SHIFT;
                        end
                    end
                    else
                    begin
                        if (count_reg == '0)
                        begin
                            res_valid_next = 1'b1;
                            status_next    = ST_EMPTY;
                            out_id_next    = '0;
                            out_pri_next   = '0;
                            occ_next       = '0;
                        end
                        else
                        begin
                            mem_raddr  = phys(head_reg, '0);
                            state_next = S_POP;
                        end
                    end
                end
            end

            S_SHIFT:
            begin
                mem_we    = 1'b1;
                mem_waddr = phys(head_reg, pos_reg);
                if (mem_rdata.pri < new_reg.pri)
                begin
                    // move the lower-priority entry up one slot
                    mem_wdata = mem_rdata;
                    pos_next  = pos_reg - 1'b1;
                    if (pos_reg == CNT_W'(1))
                    begin
                        state_next = S_PLACE;
                    end
                    else
                    begin
                        mem_raddr = phys(head_reg, pos_reg - CNT_W'(2));
                    end
                end
                else
                begin
                    mem_wdata      = new_reg;
                    count_next     = count_reg + 1'b1;
                    res_valid_next = 1'b1;
                    status_next    = ST_INSERTED;
                    out_id_next    = '0;
                    out_pri_next   = '0;
                    occ_next       = OCC_W'(count_reg + 1'b1);
                    state_next     = S_IDLE;
                end
            end

            S_PLACE:
            begin
                mem_we         = 1'b1;
                mem_waddr      = phys(head_reg, '0);
                mem_wdata      = new_reg;
                count_next     = count_reg + 1'b1;
                res_valid_next = 1'b1;
                status_next    = ST_INSERTED;
                out_id_next    = '0;
                out_pri_next   = '0;
                occ_next       = OCC_W'(count_reg + 1'b1);
                state_next     = S_IDLE;
            end

            S_POP:
            begin
                head_next      = phys(head_reg, CNT_W'(1));
                count_next     = count_reg - 1'b1;
                res_valid_next = 1'b1;
                status_next    = ST_REMOVED;
                out_id_next    = mem_rdata.id;
                out_pri_next   = mem_rdata.pri;
                occ_next       = OCC_W'(count_reg - 1'b1);
                state_next     = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        new_reg     <= new_next;
        status_reg  <= status_next;
        out_id_reg  <= out_id_next;
        out_pri_reg <= out_pri_next;
        occ_reg     <= occ_next;
    end

    assign res.valid        = res_valid_reg;
    assign res.status       = status_reg;
    assign res.out_id       = out_id_reg;
    assign res.out_priority = out_pri_reg;
    assign res.occupancy    = occ_reg;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (state_reg == S_IDLE))
        else $error("request taken while busy");

    a_pop_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |=> (res.valid && res.status == ST_REMOVED))
        else $error("pop did not produce a removed result");

    a_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.status != ST_REMOVED) |-> (res.out_id == '0 && res.out_priority == '0))
        else $error("nonzero entry on a result without removal");
`endif

endmodule

### tb/tb_stable_priority_queue.sv
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// self-checking bench for the sorted priority queue
// ----------------------------------------------------------------------------
// A scoreboard keeps its own sorted copy of the queue. It works out the result
// of every request the block takes and compares each result the block hands
// back, field by field, in order. A short directed run covers empty and full
// queues, the extreme ids and priorities and ties of equal priority. Random
// runs follow that fill and drain the queue over its whole range. The sender
// and the receiver each pause at random, in phases with different amounts of
// idling.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;
    timeunit 1ns;
    timeprecision 1ps;

    import spq_pkg::*;

    localparam int QUEUE_DEPTH  = DEFAULT_CAPACITY;
    localparam int SETTLE_TICKS = 2 * QUEUE_DEPTH + 8;
    localparam int PHASE_ITEMS  = 125;

    typedef struct {
        status_t          status;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
        logic [OCC_W-1:0] occupancy;
    } outcome_t;

    class queue_scoreboard;
        entry_t   held[$];
        outcome_t awaited[$];
        int       errors;
        int       depth;

        function new(int depth_i);
            depth  = depth_i;
            errors = 0;
        endfunction

        function void note_request(req_t kind, logic [ID_W-1:0] id,
                                   logic [PRI_W-1:0] pri);
            outcome_t o;
            entry_t   e;
            int       pos;
            o.id  = '0;
            o.pri = '0;
            if (kind == REQ_INSERT)
            begin
                if (held.size() >= depth)
                    o.status = ST_FULL;
                else
                begin
                    // behind every entry of equal or higher priority
                    pos = 0;
                    while (pos < held.size() && held[pos].pri >= pri)
                        pos++;
                    e.id  = id;
                    e.pri = pri;
                    held.insert(pos, e);
                    o.status = ST_INSERTED;
                end
            end
            else if (held.size() == 0)
                o.status = ST_EMPTY;
            else
            begin
                e        = held.pop_front();
                o.status = ST_REMOVED;
                o.id     = e.id;
                o.pri    = e.pri;
            end
            o.occupancy = OCC_W'(held.size());
            awaited.push_back(o);
        endfunction

        function void report(string field, int unsigned want, int unsigned got);
            $display("%0t: mismatch in %s: expected %0d, actual %0d", $time, field,
                     want, got);
            errors++;
        endfunction

        function void check_result(logic [1:0] status, logic [ID_W-1:0] id,
                                   logic [PRI_W-1:0] pri, logic [OCC_W-1:0] occ);
            outcome_t o;
            if (awaited.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %0d %h %h %0d",
                         $time, status, id, pri, occ);
                errors++;
                return;
            end
            o = awaited.pop_front();
            if (o.status !== status)
                report("status", o.status, status);
            if (o.id !== id)
                report("out_id", o.id, id);
            if (o.pri !== pri)
                report("out_priority", o.pri, pri);
            if (o.occupancy !== occ)
                report("occupancy", o.occupancy, occ);
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    int   src_idle_pct;
    int   sink_stall_pct;

    queue_scoreboard board;

    spq_req_if req_ch();
    spq_res_if res_ch();

    stable_priority_queue #(
        .CAPACITY (QUEUE_DEPTH)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // result side: check each transfer, then decide whether to stall
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                board.check_result(res_ch.status, res_ch.out_id, res_ch.out_priority,
                                   res_ch.occupancy);
            res_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // called at a rising edge; returns at the edge of the transfer
    task automatic send_request(input req_t kind, input logic [ID_W-1:0] id,
                                input logic [PRI_W-1:0] pri);
        while ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= kind;
        req_ch.item_id      <= id;
        req_ch.priority_req <= pri;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        board.note_request(kind, id, pri);
    endtask

    task automatic insert_entry(input logic [ID_W-1:0] id, input logic [PRI_W-1:0] pri);
        send_request(REQ_INSERT, id, pri);
    endtask

    task automatic remove_entry();
        send_request(REQ_REMOVE, ID_W'($urandom_range(16'hFFFF)),
                     PRI_W'($urandom_range(255)));
    endtask

    task automatic directed_run();
        remove_entry();
        insert_entry(16'h0000, 8'h00);
        insert_entry(16'hFFFF, 8'hFF);
        insert_entry(16'h1234, 8'h80);
        insert_entry(16'h0001, 8'h80);
        insert_entry(16'h0002, 8'h80);
        insert_entry(16'h0003, 8'h00);
        insert_entry(16'h0004, 8'hFF);
        insert_entry(16'hA5A5, 8'h5A);
        insert_entry(16'h5A5A, 8'hA5);
        insert_entry(16'h0005, 8'h80);
        insert_entry(16'h8000, 8'h01);
        insert_entry(16'h7FFF, 8'hFE);
        insert_entry(16'h0006, 8'h00);
        insert_entry(16'h0007, 8'hFF);
        insert_entry(16'hFFFE, 8'h7F);
        insert_entry(16'h0008, 8'h80);
        // queue is full now: refused
        insert_entry(16'hFFFF, 8'hFF);
        repeat (5)
            remove_entry();
    endtask

    task automatic random_run(input int count);
        int left;
        int span;
        int bias;
        int narrow;
        int base;
        left = count;
        while (left > 0)
        begin
            span = $urandom_range(40, 10);
            if (span > left)
                span = left;
            case ($urandom_range(2))
                0:       bias = 85;
                1:       bias = 50;
                default: bias = 15;
            endcase
            // narrow priority windows give many ties
            narrow = $urandom_range(1);
            base   = $urandom_range(252);
            repeat (span)
            begin
                if ($urandom_range(99) < bias)
                    insert_entry(ID_W'($urandom_range(16'hFFFF)),
                                 PRI_W'(narrow ? base + $urandom_range(3)
                                               : $urandom_range(255)));
                else
                    remove_entry();
            end
            left -= span;
        end
    endtask

    initial
    begin
        board                = new(QUEUE_DEPTH);
        src_idle_pct         = 0;
        sink_stall_pct       = 0;
        rst_n                = 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.req_type     <= REQ_INSERT;
        req_ch.item_id      <= '0;
        req_ch.priority_req <= '0;
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_run();
        random_run(PHASE_ITEMS);
        src_idle_pct = 73;
        random_run(PHASE_ITEMS);
        src_idle_pct   = 0;
        sink_stall_pct = 73;
        random_run(PHASE_ITEMS);
        src_idle_pct   = 36;
        sink_stall_pct = 36;
        random_run(PHASE_ITEMS);

        req_ch.valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS)
            @(posedge clk);

        if (board.errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
